/* sv/oahs_pkg.sv */
package oahs_pkg;

    localparam int unsigned CAPACITY_DEFAULT  = 1024;
    localparam int unsigned KEY_WIDTH_DEFAULT = 32;

    localparam int unsigned REQ_W   = 2;
    localparam int unsigned LIMIT_W = 11;
    localparam int unsigned COUNT_W = 11;

    localparam logic [LIMIT_W-1:0] MAX_USED_RESET = LIMIT_W'(768);

    localparam int unsigned HASH_MUL     = 73;
    localparam int unsigned PROBE_STRIDE = 5009;

    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd3;

endpackage

/* sv/open_addressing_hash_set_core.sv */
// Open-addressing hash set of keys with tombstones.
// Request channel: i_in_valid / o_in_ready carry i_req_type (add, remove,
// query, clear) and i_key. Result channel: o_out_valid / i_out_ready carry
// o_hit, o_full_res and o_live_count, one result beat per request beat.
// Configuration channel: i_cfg_valid / o_cfg_ready carry the fill limit on
// non-empty slots (tombstones included); the channel is always ready.
// Slots live in one table read one slot per cycle. A request
// is accepted, probes P slots in S_PROBE (1 to CAPACITY, linear stride
// from the multiplicative home slot), then passes S_DECIDE and S_DONE.
// Keys 0 and 1 go straight to S_DONE. A clear request sweeps the table
// one slot a cycle, then passes S_DONE.
// One request is handled at a time; o_in_ready is low while it runs.
// Reset starts the same sweep, with o_in_ready low and no result beat;
// configuration writes are taken during it.
// A stalled result beat holds in the output register; the next request
// is still accepted and finishes up to the point of handing over its result.
module open_addressing_hash_set_core #(
    parameter int unsigned CAPACITY  = oahs_pkg::CAPACITY_DEFAULT,
    parameter int unsigned KEY_WIDTH = oahs_pkg::KEY_WIDTH_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [oahs_pkg::REQ_W-1:0]   i_req_type,
    input  logic [KEY_WIDTH-1:0]         i_key,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_hit,
    output logic                         o_full_res,
    output logic [oahs_pkg::COUNT_W-1:0] o_live_count,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [oahs_pkg::LIMIT_W-1:0] i_cfg_data
);

    localparam int unsigned AW   = $clog2(CAPACITY);
    localparam int unsigned CW   = AW + 1;
    localparam int unsigned CMPW = (CW > oahs_pkg::LIMIT_W) ? CW : oahs_pkg::LIMIT_W;

    localparam logic [AW-1:0] HASH_MUL_A = AW'(oahs_pkg::HASH_MUL % CAPACITY);
    localparam logic [AW-1:0] STRIDE_A   = AW'(oahs_pkg::PROBE_STRIDE % CAPACITY);

    localparam logic [KEY_WIDTH-1:0] SLOT_EMPTY = KEY_WIDTH'(0);
    localparam logic [KEY_WIDTH-1:0] SLOT_TOMB  = KEY_WIDTH'(1);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_PROBE  = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [KEY_WIDTH-1:0] r_mem [CAPACITY];

    logic [2:0]                   r_state;
    logic                         r_clr_resp;
    logic [AW-1:0]                r_clr_addr;
    logic [oahs_pkg::REQ_W-1:0]   r_req;
    logic [KEY_WIDTH-1:0]         r_key;
    logic [AW-1:0]                r_pos;
    logic [AW-1:0]                r_tpos;
    logic [AW-1:0]                r_cnt;
    logic                         r_match;
    logic                         r_tomb;
    logic                         r_empty;
    logic [KEY_WIDTH-1:0]         r_rd_data;
    logic [CW-1:0]                r_live;
    logic [CW-1:0]                r_used;
    logic [oahs_pkg::LIMIT_W-1:0] r_max_used;
    logic                         r_res_hit;
    logic                         r_res_full;
    logic                         r_out_valid;
    logic                         r_out_hit;
    logic                         r_out_full;
    logic [oahs_pkg::COUNT_W-1:0] r_out_live;

    logic                 w_accept;
    logic [AW-1:0]        w_home;
    logic [AW-1:0]        w_next_pos;
    logic [AW-1:0]        w_rd_addr;
    logic                 w_wr_en;
    logic [AW-1:0]        w_wr_addr;
    logic [KEY_WIDTH-1:0] w_wr_data;
    logic                 w_is_empty;
    logic                 w_is_tomb;
    logic                 w_is_match;
    logic                 w_last;
    logic                 w_room;
    logic                 w_dec_hit;
    logic                 w_dec_full;
    logic                 w_live_inc;
    logic                 w_live_dec;
    logic                 w_used_inc;
    logic                 w_out_free;

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_hit        = r_out_hit;
    assign o_full_res   = r_out_full;
    assign o_live_count = r_out_live;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_home     = AW'(i_key) * HASH_MUL_A;
    assign w_next_pos = r_pos + STRIDE_A;
    assign w_rd_addr  = (r_state == S_IDLE) ? w_home : w_next_pos;
    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_is_empty = (r_rd_data == SLOT_EMPTY);
    assign w_is_tomb  = (r_rd_data == SLOT_TOMB);
    assign w_is_match = (r_rd_data == r_key);
    assign w_last     = (r_cnt == {AW{1'b1}});
    assign w_room     = CMPW'(r_used) < CMPW'(r_max_used);

    always_comb begin
        w_dec_hit  = 1'b0;
        w_dec_full = 1'b0;
        w_live_inc = 1'b0;
        w_live_dec = 1'b0;
        w_used_inc = 1'b0;
        w_wr_en    = 1'b0;
        w_wr_addr  = r_pos;
        w_wr_data  = r_key;
        unique case (r_req)
            oahs_pkg::REQ_ADD: begin
                if (!r_match) begin
                    if (r_tomb) begin
                        w_dec_hit  = 1'b1;
                        w_live_inc = 1'b1;
                        w_wr_en    = 1'b1;
                        w_wr_addr  = r_tpos;
                    end else if (r_empty && w_room) begin
                        w_dec_hit  = 1'b1;
                        w_live_inc = 1'b1;
                        w_used_inc = 1'b1;
                        w_wr_en    = 1'b1;
                    end else begin
                        w_dec_full = 1'b1;
                    end
                end
            end
            oahs_pkg::REQ_REMOVE: begin
                if (r_match) begin
                    w_dec_hit  = 1'b1;
                    w_live_dec = 1'b1;
                    w_wr_en    = 1'b1;
                    w_wr_data  = SLOT_TOMB;
                end
            end
            default: begin
                w_dec_hit = r_match;
            end
        endcase
        if (r_state == S_CLEAR) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_clr_addr;
            w_wr_data = SLOT_EMPTY;
        end else if (r_state != S_DECIDE) begin
            w_wr_en = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_used <= oahs_pkg::MAX_USED_RESET;
        end else if (i_cfg_valid) begin
            r_max_used <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_resp  <= 1'b0;
            r_clr_addr  <= '0;
            r_live      <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == {AW{1'b1}}) begin
                        r_live <= '0;
                        r_used <= '0;
                        if (r_clr_resp) begin
                            r_res_hit  <= 1'b1;
                            r_res_full <= 1'b0;
                            r_state    <= S_DONE;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_req      <= i_req_type;
                        r_key      <= i_key;
                        r_pos      <= w_home;
                        r_cnt      <= '0;
                        r_match    <= 1'b0;
                        r_tomb     <= 1'b0;
                        r_empty    <= 1'b0;
                        r_res_hit  <= 1'b0;
                        r_res_full <= 1'b0;
                        if (i_req_type == oahs_pkg::REQ_CLEAR) begin
                            r_clr_resp <= 1'b1;
                            r_clr_addr <= '0;
                            r_state    <= S_CLEAR;
                        end else if (i_key > SLOT_TOMB) begin
                            r_state <= S_PROBE;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_PROBE: begin
                    if (w_is_tomb && !r_tomb) begin
                        r_tomb <= 1'b1;
                        r_tpos <= r_pos;
                    end
                    priority if (w_is_empty) begin
                        r_empty <= 1'b1;
                        r_state <= S_DECIDE;
                    end else if (w_is_match) begin
                        r_match <= 1'b1;
                        r_state <= S_DECIDE;
                    end else if (w_last) begin
                        r_state <= S_DECIDE;
                    end else begin
                        r_pos <= w_next_pos;
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DECIDE: begin
                    r_res_hit  <= w_dec_hit;
                    r_res_full <= w_dec_full;
                    if (w_live_inc) begin
                        r_live <= r_live + 1'b1;
                    end else if (w_live_dec) begin
                        r_live <= r_live - 1'b1;
                    end
                    if (w_used_inc) begin
                        r_used <= r_used + 1'b1;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_hit   <= r_res_hit;
                        r_out_full  <= r_res_full;
                        r_out_live  <= oahs_pkg::COUNT_W'(r_live);
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* sv/oahs_checker.sv */
module oahs_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic                         o_hit,
    input logic                         o_full_res,
    input logic [oahs_pkg::COUNT_W-1:0] o_live_count
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_hit) && $stable(o_full_res) && $stable(o_live_count))
        else $error("result beat changed while stalled");

    a_full_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_hit && o_full_res))
        else $error("refused add reported as hit");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while busy");

    a_reset_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_in_ready && !o_out_valid)
        else $error("block not clearing after reset");

endmodule

bind open_addressing_hash_set_core oahs_checker u_oahs_checker (.*);

/* bench/tb_open_addressing_hash_set_core.sv */
`timescale 1ns / 100ps

module tb_open_addressing_hash_set_core;

    localparam int unsigned CAPACITY  = oahs_pkg::CAPACITY_DEFAULT;
    localparam int unsigned KEY_WIDTH = oahs_pkg::KEY_WIDTH_DEFAULT;
    localparam int unsigned SLOT_W    = $clog2(CAPACITY);
    localparam int unsigned POOL_SIZE = 48;

    localparam logic [KEY_WIDTH-1:0] SLOT_EMPTY = '0;
    localparam logic [KEY_WIDTH-1:0] SLOT_TOMB  = KEY_WIDTH'(1);

    typedef struct {
        logic [oahs_pkg::REQ_W-1:0]   req;
        logic [KEY_WIDTH-1:0]         key;
        logic                         hit;
        logic                         full;
        logic [oahs_pkg::COUNT_W-1:0] live;
    } t_outcome;

    class t_hash_set_scoreboard;
        logic [KEY_WIDTH-1:0]         slot_mem [CAPACITY];
        int unsigned                  live_keys;
        int unsigned                  used_slots;
        logic [oahs_pkg::LIMIT_W-1:0] fill_limit;
        t_outcome                     pending [$];
        int unsigned                  errors;
        int unsigned                  n_checked;
        int unsigned                  n_hits;
        int unsigned                  n_refused;

        function new();
            clear_table();
            fill_limit = oahs_pkg::MAX_USED_RESET;
            errors     = 0;
            n_checked  = 0;
            n_hits     = 0;
            n_refused  = 0;
        endfunction

        function void clear_table();
            foreach (slot_mem[i]) slot_mem[i] = SLOT_EMPTY;
            live_keys  = 0;
            used_slots = 0;
        endfunction

        function void note_request(logic [oahs_pkg::REQ_W-1:0] req,
                                   logic [KEY_WIDTH-1:0] key);
            t_outcome          want;
            logic [63:0]       prod;
            logic [SLOT_W-1:0] pos;
            logic [SLOT_W-1:0] match_pos;
            logic [SLOT_W-1:0] tomb_pos;
            logic [SLOT_W-1:0] empty_pos;
            bit                seen_match;
            bit                seen_tomb;
            bit                seen_empty;
            want.req   = req;
            want.key   = key;
            want.hit   = 1'b0;
            want.full  = 1'b0;
            seen_match = 0;
            seen_tomb  = 0;
            seen_empty = 0;
            match_pos  = '0;
            tomb_pos   = '0;
            empty_pos  = '0;
            if (req == oahs_pkg::REQ_CLEAR) begin
                clear_table();
                want.hit = 1'b1;
            end else if (key > SLOT_TOMB) begin
                prod = 64'(key) * 64'(oahs_pkg::HASH_MUL);
                pos  = prod[SLOT_W-1:0];
                for (int n = 0; n < CAPACITY; n++) begin
                    if (slot_mem[pos] == SLOT_EMPTY) begin
                        empty_pos  = pos;
                        seen_empty = 1;
                        break;
                    end
                    if (slot_mem[pos] == SLOT_TOMB) begin
                        if (!seen_tomb) begin
                            tomb_pos  = pos;
                            seen_tomb = 1;
                        end
                    end else if (slot_mem[pos] == key) begin
                        match_pos  = pos;
                        seen_match = 1;
                        break;
                    end
                    pos = pos + SLOT_W'(oahs_pkg::PROBE_STRIDE);
                end
                case (req)
                    oahs_pkg::REQ_ADD: begin
                        if (!seen_match) begin
                            if (seen_tomb) begin
                                slot_mem[tomb_pos] = key;
                                live_keys++;
                                want.hit = 1'b1;
                            end else if (seen_empty && used_slots < fill_limit) begin
                                slot_mem[empty_pos] = key;
                                used_slots++;
                                live_keys++;
                                want.hit = 1'b1;
                            end else begin
                                want.full = 1'b1;
                            end
                        end
                    end
                    oahs_pkg::REQ_REMOVE: begin
                        if (seen_match) begin
                            slot_mem[match_pos] = SLOT_TOMB;
                            live_keys--;
                            want.hit = 1'b1;
                        end
                    end
                    default: want.hit = seen_match;
                endcase
            end
            want.live = oahs_pkg::COUNT_W'(live_keys);
            pending.push_back(want);
        endfunction

        function void check_result(logic hit, logic full,
                                   logic [oahs_pkg::COUNT_W-1:0] live);
            t_outcome want;
            if (pending.size() == 0) begin
                $display("%0t: result beat with nothing outstanding: hit %0b full %0b live %0d",
                         $time, hit, full, live);
                errors++;
                return;
            end
            want = pending.pop_front();
            n_checked++;
            if (want.hit) n_hits++;
            if (want.full) n_refused++;
            if (hit !== want.hit) begin
                $display("%0t: req %0d key %h: hit expected %0b actual %0b",
                         $time, want.req, want.key, want.hit, hit);
                errors++;
            end
            if (full !== want.full) begin
                $display("%0t: req %0d key %h: full_res expected %0b actual %0b",
                         $time, want.req, want.key, want.full, full);
                errors++;
            end
            if (live !== want.live) begin
                $display("%0t: req %0d key %h: live_count expected %0d actual %0d",
                         $time, want.req, want.key, want.live, live);
                errors++;
            end
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_ready;
    logic [oahs_pkg::REQ_W-1:0]   i_req_type;
    logic [KEY_WIDTH-1:0]         i_key;
    logic                         o_out_valid;
    logic                         i_out_ready;
    logic                         o_hit;
    logic                         o_full_res;
    logic [oahs_pkg::COUNT_W-1:0] o_live_count;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [oahs_pkg::LIMIT_W-1:0] i_cfg_data;

    t_hash_set_scoreboard sb;
    bit                   sender_burst;
    bit                   recv_burst;
    int unsigned          results_seen;
    int unsigned          wait_left;
    logic [KEY_WIDTH-1:0] key_pool [POOL_SIZE];

    open_addressing_hash_set_core #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_req_type   (i_req_type),
        .i_key        (i_key),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_hit        (o_hit),
        .o_full_res   (o_full_res),
        .o_live_count (o_live_count),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // result side: sample at rising edge, drive ready at falling edge
    initial begin
        i_out_ready  = 1'b0;
        results_seen = 0;
        wait_left    = 0;
        recv_burst   = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                sb.check_result(o_hit, o_full_res, o_live_count);
                results_seen++;
                if (results_seen % 64 == 0) recv_burst = ($urandom_range(0, 3) == 0);
                if (results_seen == 400) wait_left = 600;
                else wait_left = recv_burst ? 0 : $urandom_range(0, 16);
            end
            @(negedge i_clk);
            if (wait_left > 0) begin
                i_out_ready <= 1'b0;
                wait_left--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic send_request(input logic [oahs_pkg::REQ_W-1:0] req,
                                input logic [KEY_WIDTH-1:0] key);
        int unsigned gap;
        gap = sender_burst ? 0 : $urandom_range(0, 16);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_key      <= key;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(req, key);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending.size() > 0) @(posedge i_clk);
    endtask

    task automatic write_fill_limit(input logic [oahs_pkg::LIMIT_W-1:0] limit);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= limit;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.fill_limit = limit;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [KEY_WIDTH-1:0] fresh_key();
        logic [KEY_WIDTH-1:0] k;
        k = KEY_WIDTH'($urandom);
        if (k <= SLOT_TOMB) k = k + KEY_WIDTH'(2);
        return k;
    endfunction

    task automatic run_mixed_phase(input int unsigned count);
        int unsigned                r;
        logic [oahs_pkg::REQ_W-1:0] req;
        logic [KEY_WIDTH-1:0]       key;
        for (int i = 0; i < POOL_SIZE; i++) begin
            if (i % 2 == 0) key_pool[i] = fresh_key();
            else key_pool[i] = key_pool[i-1] + KEY_WIDTH'($urandom_range(1, 3) * CAPACITY);
        end
        for (int unsigned i = 0; i < count; i++) begin
            if (i % 50 == 0) sender_burst = ($urandom_range(0, 3) == 0);
            r   = $urandom_range(0, 99);
            key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            if (r < 2) begin
                req = oahs_pkg::REQ_CLEAR;
            end else if (r < 7) begin
                req = oahs_pkg::REQ_W'($urandom_range(oahs_pkg::REQ_ADD, oahs_pkg::REQ_QUERY));
                key = $urandom_range(0, 1) ? SLOT_TOMB : SLOT_EMPTY;
            end else if (r < 12) begin
                req = oahs_pkg::REQ_W'($urandom_range(oahs_pkg::REQ_ADD, oahs_pkg::REQ_QUERY));
                key = KEY_WIDTH'($urandom);
            end else if (r < 52) begin
                req = oahs_pkg::REQ_ADD;
            end else if (r < 74) begin
                req = oahs_pkg::REQ_REMOVE;
            end else begin
                req = oahs_pkg::REQ_QUERY;
            end
            send_request(req, key);
        end
        drain_results();
    endtask

    initial begin
        logic [oahs_pkg::REQ_W-1:0]   dir_req [23];
        logic [KEY_WIDTH-1:0]         dir_key [23];
        logic [oahs_pkg::LIMIT_W-1:0] limits [7];
        logic [KEY_WIDTH-1:0]         first_key;
        int unsigned                  tries;

        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_req_type   = oahs_pkg::REQ_ADD;
        i_key        = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        sender_burst = 0;
        sb           = new();

        // keys 2, 1026 and 2050 share a home slot
        dir_req = '{oahs_pkg::REQ_ADD, oahs_pkg::REQ_ADD, oahs_pkg::REQ_QUERY,
                    oahs_pkg::REQ_REMOVE, oahs_pkg::REQ_ADD, oahs_pkg::REQ_ADD,
                    oahs_pkg::REQ_ADD, oahs_pkg::REQ_QUERY, oahs_pkg::REQ_REMOVE,
                    oahs_pkg::REQ_QUERY, oahs_pkg::REQ_ADD, oahs_pkg::REQ_ADD,
                    oahs_pkg::REQ_REMOVE, oahs_pkg::REQ_ADD, oahs_pkg::REQ_ADD,
                    oahs_pkg::REQ_ADD, oahs_pkg::REQ_REMOVE, oahs_pkg::REQ_ADD,
                    oahs_pkg::REQ_QUERY, oahs_pkg::REQ_CLEAR, oahs_pkg::REQ_QUERY,
                    oahs_pkg::REQ_ADD, oahs_pkg::REQ_CLEAR};
        dir_key = '{SLOT_EMPTY, SLOT_TOMB, SLOT_EMPTY, SLOT_TOMB, 32'd2, 32'd2, 32'd1026,
                    32'd1026, 32'd2, 32'd1026, 32'd1026, 32'd2050, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 32'h8000_0000, 32'd3, 32'h8000_0000, 32'd3,
                    32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd3, 32'h5555_AAAA};
        limits  = '{11'd1, 11'd16, 11'd1023, 11'd1024, 11'd40, 11'd2,
                    oahs_pkg::MAX_USED_RESET};
        limits[4] = oahs_pkg::LIMIT_W'($urandom_range(3, 1000));

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_fill_limit(11'd4);
        for (int i = 0; i < 23; i++) send_request(dir_req[i], dir_key[i]);
        drain_results();

        // fill every slot, then probe a table with no empty slot left
        write_fill_limit(11'd1024);
        send_request(oahs_pkg::REQ_CLEAR, '0);
        first_key = fresh_key();
        send_request(oahs_pkg::REQ_ADD, first_key);
        tries = 0;
        while (sb.live_keys < CAPACITY && tries < 4 * CAPACITY) begin
            send_request(oahs_pkg::REQ_ADD, fresh_key());
            tries++;
        end
        send_request(oahs_pkg::REQ_ADD, fresh_key());
        send_request(oahs_pkg::REQ_QUERY, fresh_key());
        send_request(oahs_pkg::REQ_REMOVE, fresh_key());
        send_request(oahs_pkg::REQ_QUERY, first_key);
        send_request(oahs_pkg::REQ_REMOVE, first_key);
        send_request(oahs_pkg::REQ_ADD, fresh_key());
        send_request(oahs_pkg::REQ_ADD, fresh_key());
        send_request(oahs_pkg::REQ_CLEAR, '0);
        drain_results();

        foreach (limits[p]) begin
            write_fill_limit(limits[p]);
            run_mixed_phase(75);
        end

        repeat (1100) @(posedge i_clk);
        if (sb.pending.size() > 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.pending.size());
            sb.errors++;
        end
        $display("Summary: %0d requests checked, %0d hits, %0d adds refused for room",
                 sb.n_checked, sb.n_hits, sb.n_refused);
        $display("Summary: fill limits 1 to 1024, one pass with every slot taken, %0d errors",
                 sb.errors);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/oahs_pkg.sv
sv/open_addressing_hash_set_core.sv
sv/oahs_checker.sv
bench/tb_open_addressing_hash_set_core.sv
